@@ sv/lmfs_pkg.sv @@
// Shared types, codes and constants of the LED matrix frame scanner.
`default_nettype none

package lmfs_pkg;

    // Field and word widths fixed by the command and result formats.
    localparam int POS_W   = 5;
    localparam int SIZE_W  = 4;
    localparam int COORD_W = 3;
    localparam int PIX_W   = 3;
    localparam int WORD_W  = 8;

    // Default matrix geometry.
    localparam int COLUMNS_DEF = 8;
    localparam int ROWS_DEF    = 8;

    // Pixel value that a rectangle fill writes: blue only.
    localparam logic [PIX_W-1:0] PIX_BLUE = 3'b001;

    // Command codes.
    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_PIXEL   = 2'd1,
        FUNC_RECT    = 2'd2,
        FUNC_REFRESH = 2'd3
    } func_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Control from the sequencer to the frame store.
    typedef struct packed {
        logic wr_en;
        logic clr;
        logic rd_en;
    } store_ctl_t;

    // One lit pixel found by the scan, handed to the output stage.
    typedef struct packed {
        logic               vld;
        logic               blue;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } scan_item_t;

endpackage

`default_nettype wire

@@ sv/lmfs_store.sv @@
// Frame store memory with per-entry valid bits and a registered read port.
`default_nettype none

module lmfs_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire lmfs_pkg::store_ctl_t       ctl,
    input  wire [ADDR_W-1:0]                addr,
    input  wire [lmfs_pkg::PIX_W-1:0]       wr_data,
    output logic [lmfs_pkg::PIX_W-1:0]      rd_data
);

    logic [lmfs_pkg::PIX_W-1:0] mem [0:DEPTH-1];
    logic [DEPTH-1:0]           valid_reg;
    logic [lmfs_pkg::PIX_W-1:0] q_data_reg;
    logic                       q_vld_reg;

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Valid bits: an entry that was never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clr)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            q_data_reg <= mem[addr];
            q_vld_reg  <= valid_reg[addr];
        end
    end

    assign rd_data = q_vld_reg ? q_data_reg : '0;

endmodule

`default_nettype wire

@@ sv/lmfs_seq.sv @@
// Command sequencer: decodes commands, walks rectangle fills and refresh scans.
`default_nettype none

module lmfs_seq #(
    parameter int COLUMNS = 8,
    parameter int ROWS    = 8,
    parameter int DEPTH   = 64,
    parameter int ADDR_W  = 6
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cmd_valid,
    output logic                             cmd_ready,
    input  wire [1:0]                        func,
    input  wire [lmfs_pkg::POS_W-1:0]        pos_x,
    input  wire [lmfs_pkg::POS_W-1:0]        pos_y,
    input  wire                              red,
    input  wire                              green,
    input  wire                              blue,
    input  wire [lmfs_pkg::SIZE_W-1:0]       rect_width,
    input  wire [lmfs_pkg::SIZE_W-1:0]       rect_height,
    input  wire [lmfs_pkg::PIX_W-1:0]        store_q,
    input  wire                              push_ok,
    output lmfs_pkg::store_ctl_t             store_ctl,
    output logic [ADDR_W-1:0]                store_addr,
    output logic [lmfs_pkg::PIX_W-1:0]       store_data,
    output lmfs_pkg::scan_item_t             item,
    output logic                             flush
);

    localparam logic [lmfs_pkg::COORD_W-1:0] X_MAX = lmfs_pkg::COORD_W'(COLUMNS - 1);
    localparam logic [lmfs_pkg::COORD_W-1:0] Y_MAX = lmfs_pkg::COORD_W'(ROWS - 1);

    lmfs_pkg::state_t state_reg;
    lmfs_pkg::state_t state_next;
    lmfs_pkg::func_t  cmd_func;

    logic [lmfs_pkg::COORD_W-1:0] fx_reg;
    logic [lmfs_pkg::COORD_W-1:0] fy_reg;
    logic [lmfs_pkg::COORD_W-1:0] fy0_reg;
    logic [lmfs_pkg::COORD_W-1:0] fx_last_reg;
    logic [lmfs_pkg::COORD_W-1:0] fy_last_reg;
    logic [lmfs_pkg::COORD_W-1:0] sx_reg;
    logic [lmfs_pkg::COORD_W-1:0] sy_reg;
    logic [ADDR_W-1:0]            scan_addr_reg;
    logic                         issue_done_reg;
    logic                         s2_vld_reg;
    logic [lmfs_pkg::COORD_W-1:0] s2_x_reg;
    logic [lmfs_pkg::COORD_W-1:0] s2_y_reg;

    logic                         accept;
    logic                         pix_ok;
    logic                         rect_ok;
    logic [lmfs_pkg::POS_W-1:0]   x_end;
    logic [lmfs_pkg::POS_W-1:0]   y_end;
    logic [lmfs_pkg::POS_W-1:0]   x_last;
    logic [lmfs_pkg::POS_W-1:0]   y_last;
    logic                         lit;
    logic                         stall;
    logic                         fill_done;

    assign cmd_func = lmfs_pkg::func_t'(func);
    assign accept   = cmd_valid && cmd_ready;

    // Range checks for pixel writes and rectangle fills.
    assign pix_ok = !pos_x[lmfs_pkg::POS_W-1] && !pos_y[lmfs_pkg::POS_W-1]
                 && ({1'b0, pos_x[lmfs_pkg::POS_W-2:0]} < lmfs_pkg::POS_W'(COLUMNS))
                 && ({1'b0, pos_y[lmfs_pkg::POS_W-2:0]} < lmfs_pkg::POS_W'(ROWS));

    assign x_end  = {1'b0, pos_x[lmfs_pkg::POS_W-2:0]} + {1'b0, rect_width};
    assign y_end  = {1'b0, pos_y[lmfs_pkg::POS_W-2:0]} + {1'b0, rect_height};
    assign x_last = x_end - lmfs_pkg::POS_W'(1);
    assign y_last = y_end - lmfs_pkg::POS_W'(1);

    assign rect_ok = !pos_x[lmfs_pkg::POS_W-1] && !pos_y[lmfs_pkg::POS_W-1]
                  && (x_end <= lmfs_pkg::POS_W'(COLUMNS))
                  && (y_end <= lmfs_pkg::POS_W'(ROWS))
                  && (rect_width != '0) && (rect_height != '0);

    assign fill_done = (fx_reg == fx_last_reg) && (fy_reg == fy_last_reg);

    // Scan stage two: the registered read data is checked for a lit pixel.
    assign lit   = s2_vld_reg && (store_q != '0);
    assign stall = lit && !push_ok;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_func == lmfs_pkg::FUNC_RECT && rect_ok)
                    begin
                        state_next = lmfs_pkg::ST_FILL;
                    end
                    else if (cmd_func == lmfs_pkg::FUNC_REFRESH)
                    begin
                        state_next = lmfs_pkg::ST_SCAN;
                    end
                end
            end
            lmfs_pkg::ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            lmfs_pkg::ST_SCAN:
            begin
                if (issue_done_reg && !s2_vld_reg)
                begin
                    state_next = lmfs_pkg::ST_FLUSH;
                end
            end
            lmfs_pkg::ST_FLUSH:
            begin
                if (push_ok)
                begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs to the store, the output stage and the command channel.
    always_comb
    begin
        cmd_ready       = 1'b0;
        store_ctl.wr_en = 1'b0;
        store_ctl.clr   = 1'b0;
        store_ctl.rd_en = 1'b0;
        store_addr      = scan_addr_reg;
        store_data      = lmfs_pkg::PIX_BLUE;
        item.vld        = 1'b0;
        item.blue       = store_q[0];
        item.x          = s2_x_reg;
        item.y          = s2_y_reg;
        flush           = 1'b0;
        case (state_reg)
            lmfs_pkg::ST_IDLE:
            begin
                cmd_ready       = 1'b1;
                store_ctl.clr   = cmd_valid && (cmd_func == lmfs_pkg::FUNC_CLEAR);
                store_ctl.wr_en = cmd_valid && (cmd_func == lmfs_pkg::FUNC_PIXEL) && pix_ok;
                store_addr      = ADDR_W'(pos_x[lmfs_pkg::COORD_W-1:0] * ROWS
                                        + pos_y[lmfs_pkg::COORD_W-1:0]);
                store_data      = {red, green, blue};
            end
            lmfs_pkg::ST_FILL:
            begin
                store_ctl.wr_en = 1'b1;
                store_addr      = ADDR_W'(fx_reg * ROWS + fy_reg);
            end
            lmfs_pkg::ST_SCAN:
            begin
                store_ctl.rd_en = !issue_done_reg && !stall;
                item.vld        = lit && push_ok;
            end
            lmfs_pkg::ST_FLUSH:
            begin
                flush = 1'b1;
            end
            default:
            begin
                flush = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Fill and scan counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg         <= '0;
            fy_reg         <= '0;
            fy0_reg        <= '0;
            fx_last_reg    <= '0;
            fy_last_reg    <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s2_x_reg       <= '0;
            s2_y_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                lmfs_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        fx_reg         <= pos_x[lmfs_pkg::COORD_W-1:0];
                        fy_reg         <= pos_y[lmfs_pkg::COORD_W-1:0];
                        fy0_reg        <= pos_y[lmfs_pkg::COORD_W-1:0];
                        fx_last_reg    <= x_last[lmfs_pkg::COORD_W-1:0];
                        fy_last_reg    <= y_last[lmfs_pkg::COORD_W-1:0];
                        sx_reg         <= '0;
                        sy_reg         <= '0;
                        scan_addr_reg  <= '0;
                        issue_done_reg <= 1'b0;
                        s2_vld_reg     <= 1'b0;
                    end
                end
                lmfs_pkg::ST_FILL:
                begin
                    // Rows inside a column first, then the next column.
                    if (fy_reg == fy_last_reg)
                    begin
                        fy_reg <= fy0_reg;
                        fx_reg <= fx_reg + 1'b1;
                    end
                    else
                    begin
                        fy_reg <= fy_reg + 1'b1;
                    end
                end
                lmfs_pkg::ST_SCAN:
                begin
                    if (!stall)
                    begin
                        if (!issue_done_reg)
                        begin
                            s2_vld_reg    <= 1'b1;
                            s2_x_reg      <= sx_reg;
                            s2_y_reg      <= sy_reg;
                            scan_addr_reg <= scan_addr_reg + 1'b1;
                            if (sy_reg == Y_MAX)
                            begin
                                sy_reg <= '0;
                                if (sx_reg == X_MAX)
                                begin
                                    issue_done_reg <= 1'b1;
                                end
                                else
                                begin
                                    sx_reg <= sx_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                sy_reg <= sy_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            s2_vld_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    s2_vld_reg <= 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The store has a single address, so a read and a write never share a cycle.
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_ctl.rd_en && store_ctl.wr_en))
        else $error("frame store read and write in the same cycle");

    // Every write lands inside the frame.
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        store_ctl.wr_en |-> (store_addr < DEPTH))
        else $error("frame store write address out of range");

    // The final flush starts only after the scan pipeline has drained.
    a_flush_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmfs_pkg::ST_FLUSH) |-> !s2_vld_reg)
        else $error("flush with a scan entry still in flight");
`endif

endmodule

`default_nettype wire

@@ sv/lmfs_out.sv @@
// Result stage: holds one lit pixel back to flag the last one, then the output register.
`default_nettype none

module lmfs_out (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire lmfs_pkg::scan_item_t        item,
    input  wire                              flush,
    output logic                             push_ok,
    input  wire                              res_ready,
    output logic                             res_valid,
    output logic [lmfs_pkg::WORD_W-1:0]      column_bits,
    output logic [lmfs_pkg::WORD_W-1:0]      row_bits,
    output logic                             last
);

    logic                          pend_vld_reg;
    logic [lmfs_pkg::WORD_W-1:0]   pend_col_reg;
    logic [lmfs_pkg::WORD_W-1:0]   pend_row_reg;
    logic                          res_vld_reg;
    logic [lmfs_pkg::WORD_W-1:0]   res_col_reg;
    logic [lmfs_pkg::WORD_W-1:0]   res_row_reg;
    logic                          last_reg;
    logic                          out_free;
    logic [lmfs_pkg::WORD_W-1:0]   item_col;
    logic [lmfs_pkg::WORD_W-1:0]   item_row;

    // Drive words of the new pixel.
    assign item_col = lmfs_pkg::WORD_W'(item.blue) << item.x;
    assign item_row = ~(lmfs_pkg::WORD_W'(1) << item.y);

    // The output register frees up this cycle if empty or being taken.
    assign out_free = !res_vld_reg || res_ready;
    assign push_ok  = !pend_vld_reg || out_free;

    // A new pixel pushes the held one out as a middle result; a flush sends it as last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            pend_col_reg <= '0;
            pend_row_reg <= '0;
            res_vld_reg  <= 1'b0;
            res_col_reg  <= '0;
            res_row_reg  <= '0;
            last_reg     <= 1'b0;
        end
        else if (item.vld)
        begin
            pend_vld_reg <= 1'b1;
            pend_col_reg <= item_col;
            pend_row_reg <= item_row;
            if (pend_vld_reg)
            begin
                res_vld_reg <= 1'b1;
                res_col_reg <= pend_col_reg;
                res_row_reg <= pend_row_reg;
                last_reg    <= 1'b0;
            end
            else if (res_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
        else if (flush && pend_vld_reg && out_free)
        begin
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b1;
            res_col_reg  <= pend_col_reg;
            res_row_reg  <= pend_row_reg;
            last_reg     <= 1'b1;
        end
        else if (res_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    assign res_valid   = res_vld_reg;
    assign column_bits = res_col_reg;
    assign row_bits    = res_row_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // The held pixel leaves as the last result when the scan ends.
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (flush && pend_vld_reg && out_free) |=> (res_vld_reg && last_reg))
        else $error("flushed result not flagged as last");

    // A pixel displaced by a newer one is never flagged as last.
    a_push_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (item.vld && pend_vld_reg) |=> (res_vld_reg && !last_reg))
        else $error("middle result flagged as last");
`endif

endmodule

`default_nettype wire

@@ sv/led_matrix_frame_scanner.sv @@
// Clear, pixel write and a rectangle that is empty or off the frame each finish in the cycle of acceptance.
// A rectangle fill writes one entry per cycle and takes no new command until the whole rectangle is written.
// A refresh reads one entry per cycle while result transfers do not stall; each result waits until
// the next lit pixel is found, the last one until the scan ends.
// Reset clears the control state and the per-entry valid bits at once, so the frame reads dark
// immediately after reset with no clearing pass.
`default_nettype none

module led_matrix_frame_scanner #(
    parameter int COLUMNS = lmfs_pkg::COLUMNS_DEF,
    parameter int ROWS    = lmfs_pkg::ROWS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cmd_valid,
    output logic                             cmd_ready,
    input  wire [1:0]                        func,
    input  wire [lmfs_pkg::POS_W-1:0]        pos_x,
    input  wire [lmfs_pkg::POS_W-1:0]        pos_y,
    input  wire                              red,
    input  wire                              green,
    input  wire                              blue,
    input  wire [lmfs_pkg::SIZE_W-1:0]       rect_width,
    input  wire [lmfs_pkg::SIZE_W-1:0]       rect_height,
    output logic                             res_valid,
    input  wire                              res_ready,
    output logic [lmfs_pkg::WORD_W-1:0]      column_bits,
    output logic [lmfs_pkg::WORD_W-1:0]      row_bits,
    output logic                             last
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lmfs_pkg::store_ctl_t        store_ctl;
    logic [ADDR_W-1:0]           store_addr;
    logic [lmfs_pkg::PIX_W-1:0]  store_data;
    logic [lmfs_pkg::PIX_W-1:0]  store_q;
    lmfs_pkg::scan_item_t        item;
    logic                        flush;
    logic                        push_ok;

    // Frame store.
    lmfs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (store_ctl),
        .addr    (store_addr),
        .wr_data (store_data),
        .rd_data (store_q)
    );

    // Command sequencer.
    lmfs_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .store_q     (store_q),
        .push_ok     (push_ok),
        .store_ctl   (store_ctl),
        .store_addr  (store_addr),
        .store_data  (store_data),
        .item        (item),
        .flush       (flush)
    );

    // Result stage.
    lmfs_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .flush       (flush),
        .push_ok     (push_ok),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .column_bits (column_bits),
        .row_bits    (row_bits),
        .last        (last)
    );

endmodule

`default_nettype wire
